// ===== design/ordered_array_list_engine_macros.svh =====
// assertion helpers used by the oale_core design file
`ifndef ORDERED_ARRAY_LIST_ENGINE_MACROS_SVH
`define ORDERED_ARRAY_LIST_ENGINE_MACROS_SVH

// same-cycle implication, checked on clk with rst masking
`define OALE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on clk with rst masking
`define OALE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/oale_pkg.sv =====
package oale_pkg;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_CHANGE = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_DELETE = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_BAD_POS   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    req_kind_t          kind;
    logic [7:0]         position;
    logic signed [31:0] value;
  } core_req_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] found_position;
    logic [7:0] list_length;
  } core_res_t;

endpackage

// ===== design/oale_if.sv =====
interface oale_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [7:0]         position;
  logic signed [31:0] value;

  modport source (output valid, output req_type, output position, output value, input ready);
  modport sink (input valid, input req_type, input position, input value, output ready);
endinterface

interface oale_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] found_position;
  logic [7:0] list_length;

  modport source (output valid, output status, output found_position, output list_length,
                  input ready);
  modport sink (input valid, input status, input found_position, input list_length,
                output ready);
endinterface

// ===== design/oale_core.sv =====
`include "ordered_array_list_engine_macros.svh"

module oale_core #(
  parameter int LIST_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                idle,
  input  oale_pkg::core_req_t req,
  output logic                res_valid,
  input  logic                res_take,
  output oale_pkg::core_res_t res
);
  import oale_pkg::*;

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_PUT  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t         state;
  req_kind_t      kind;
  logic [31:0]    val;
  logic [AW-1:0]  put_idx;
  logic [AW-1:0]  end_idx;
  logic [AW-1:0]  ptr;
  logic [AW-1:0]  rptr;
  logic           more;
  logic           rv;
  logic [CW-1:0]  cnt;
  status_t        st;
  logic [7:0]     where;

  logic [31:0]    mem [LIST_DEPTH];
  logic [31:0]    rdata;

  logic           we;
  logic           re;
  logic [AW-1:0]  waddr;
  logic [AW-1:0]  raddr;
  logic [31:0]    wdata;

  logic [8:0]     pos9;
  logic [8:0]     cnt9;
  logic [AW-1:0]  pidx;
  logic [AW-1:0]  cidx;
  logic           append;
  status_t        chk_st;

  assign pos9   = {1'b0, req.position};
  assign cnt9   = 9'(cnt);
  assign pidx   = AW'(req.position - 8'd1);
  assign cidx   = AW'(cnt - CW'(1));
  assign append = (pos9 == cnt9 + 9'd1);

  // request check against depth and current length
  always_comb begin
    chk_st = ST_OK;
    case (req.kind)
      REQ_INSERT: begin
        if (pos9 > 9'(LIST_DEPTH)) chk_st = ST_OVERFLOW;
        else if (req.position == 8'd0 || pos9 > cnt9 + 9'd1) chk_st = ST_BAD_POS;
        else if (cnt == CW'(LIST_DEPTH)) chk_st = ST_OVERFLOW;
      end
      REQ_CHANGE, REQ_DELETE: begin
        if (pos9 > 9'(LIST_DEPTH)) chk_st = ST_OVERFLOW;
        else if (req.position == 8'd0 || pos9 > cnt9) chk_st = ST_BAD_POS;
      end
      default: chk_st = ST_OK;
    endcase
  end

  // memory port control
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = put_idx;
    wdata = val;
    raddr = ptr;
    case (state)
      S_IDLE: begin
        if (start && chk_st == ST_OK &&
            (req.kind == REQ_CHANGE || (req.kind == REQ_INSERT && append))) begin
          we    = 1'b1;
          waddr = pidx;
          wdata = req.value;
        end
      end
      S_WALK: begin
        re = more;
        if (rv && kind == REQ_INSERT) begin
          we    = 1'b1;
          waddr = rptr + AW'(1);
          wdata = rdata;
        end else if (rv && kind == REQ_DELETE) begin
          we    = 1'b1;
          waddr = rptr - AW'(1);
          wdata = rdata;
        end
      end
      S_PUT: we = 1'b1;
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      rv    <= 1'b0;
      more  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            kind    <= req.kind;
            val     <= req.value;
            put_idx <= pidx;
            where   <= 8'd0;
            st      <= chk_st;
            rv      <= 1'b0;
            state   <= S_DONE;
            if (chk_st == ST_OK) begin
              case (req.kind)
                REQ_INSERT: begin
                  if (append) begin
                    cnt <= cnt + CW'(1);
                  end else begin
                    ptr     <= cidx;
                    end_idx <= pidx;
                    more    <= 1'b1;
                    state   <= S_WALK;
                  end
                end
                REQ_DELETE: begin
                  if (pos9 == cnt9) begin
                    cnt <= cnt - CW'(1);
                  end else begin
                    ptr     <= AW'(req.position);
                    end_idx <= cidx;
                    more    <= 1'b1;
                    state   <= S_WALK;
                  end
                end
                REQ_SEARCH: begin
                  if (cnt == '0) begin
                    st <= ST_NOT_FOUND;
                  end else begin
                    ptr     <= '0;
                    end_idx <= cidx;
                    more    <= 1'b1;
                    state   <= S_WALK;
                  end
                end
                default: state <= S_DONE;
              endcase
            end
          end
        end
        S_WALK: begin
          rv   <= more;
          rptr <= ptr;
          if (more) begin
            if (ptr == end_idx) more <= 1'b0;
            else if (kind == REQ_INSERT) ptr <= ptr - AW'(1);
            else ptr <= ptr + AW'(1);
          end
          if (rv) begin
            if (kind == REQ_SEARCH && rdata == val) begin
              where <= 8'(rptr) + 8'd1;
              st    <= ST_OK;
              more  <= 1'b0;
              rv    <= 1'b0;
              state <= S_DONE;
            end else if (!more) begin
              rv <= 1'b0;
              case (kind)
                REQ_INSERT: state <= S_PUT;
                REQ_DELETE: begin
                  cnt   <= cnt - CW'(1);
                  state <= S_DONE;
                end
                default: begin
                  st    <= ST_NOT_FOUND;
                  state <= S_DONE;
                end
              endcase
            end
          end
        end
        S_PUT: begin
          cnt   <= cnt + CW'(1);
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_take) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign idle               = (state == S_IDLE);
  assign res_valid          = (state == S_DONE);
  assign res.status         = st;
  assign res.found_position = where;
  assign res.list_length    = 8'(cnt);

  `OALE_ASSERT_NOW(a_cnt_max, 1'b1, cnt <= CW'(LIST_DEPTH), "entry count above depth")
  `OALE_ASSERT_NOW(a_rw_apart, we && re, waddr != raddr, "shift reads the entry it writes")
  `OALE_ASSERT_NEXT(a_cnt_idle, state == S_IDLE && !start, $stable(cnt),
                    "entry count moved with no request")
  `OALE_ASSERT_NOW(a_walk_only, re, state == S_WALK, "memory read outside a walk")

endmodule

// ===== design/ordered_array_list_engine.sv =====
// channel  dir  fields                                       item
// req      in   req_type[1:0] position[7:0] value[31:0]      one request
// rsp      out  status[1:0] found_position[7:0] list_length  one result per request
//
// one request at a time; a non-append insert, a delete before the last entry and a search
// of a non-empty list walk the list memory; append, change and rejected requests do not
// the walk is one read of the list memory per cycle, with the shifted write alongside
// rst clears the entry count and the sequencer; list contents are not cleared
// a result waiting in the output register does not block the next request

module ordered_array_list_engine #(
  parameter int LIST_DEPTH = 64
) (
  input logic        clk,
  input logic        rst,
  oale_req_if.sink   req,
  oale_rsp_if.source rsp
);
  import oale_pkg::*;

  logic      idle;
  logic      start;
  logic      res_valid;
  logic      res_take;
  core_req_t core_req;
  core_res_t core_res;
  core_res_t out_res;
  logic      out_valid;

  assign req.ready       = idle && !rst;
  assign start           = req.valid && req.ready;
  assign core_req.kind     = req_kind_t'(req.req_type);
  assign core_req.position = req.position;
  assign core_req.value    = req.value;

  oale_core #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .idle      (idle),
    .req       (core_req),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (core_res)
  );

  assign res_take = res_valid && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) out_res <= core_res;
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_res.status;
  assign rsp.found_position = out_res.found_position;
  assign rsp.list_length    = out_res.list_length;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import oale_pkg::*;

  localparam int LIST_DEPTH = 64;
  localparam int RANDOM_ITEMS = 1900;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_CYCLES = 80;
  localparam int HOLD_AT = 500;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    req_kind_t   kind;
    logic [7:0]  pos;
    logic [31:0] val;
    bit          typed;
    core_res_t   res;
  } step_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  oale_req_if req_bus ();
  oale_rsp_if rsp_bus ();

  ordered_array_list_engine #(.LIST_DEPTH(LIST_DEPTH)) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  always #5 clk = ~clk;

  logic [31:0] list_model [LIST_DEPTH];
  int          list_count = 0;
  core_res_t   result_q [$];
  int          mismatches = 0;
  int          sent_count = 0;
  int          rsp_seen = 0;
  step_row_t   dir_rows [24];

  function automatic core_res_t list_apply(req_kind_t kind, logic [7:0] pos, logic [31:0] val);
    core_res_t r;
    int p;
    r.status = ST_OK;
    r.found_position = 8'd0;
    p = int'(pos);
    case (kind)
      REQ_INSERT: begin
        if (p > LIST_DEPTH) r.status = ST_OVERFLOW;
        else if (p < 1 || p > list_count + 1) r.status = ST_BAD_POS;
        else if (list_count >= LIST_DEPTH) r.status = ST_OVERFLOW;
        else begin
          for (int k = list_count; k > p - 1; k--) list_model[k] = list_model[k - 1];
          list_model[p - 1] = val;
          list_count++;
        end
      end
      REQ_CHANGE: begin
        if (p > LIST_DEPTH) r.status = ST_OVERFLOW;
        else if (p < 1 || p > list_count) r.status = ST_BAD_POS;
        else list_model[p - 1] = val;
      end
      REQ_SEARCH: begin
        r.status = ST_NOT_FOUND;
        for (int k = 0; k < list_count; k++) begin
          if (r.status == ST_NOT_FOUND && list_model[k] == val) begin
            r.status = ST_OK;
            r.found_position = 8'(k + 1);
          end
        end
      end
      default: begin
        if (p > LIST_DEPTH) r.status = ST_OVERFLOW;
        else if (p < 1 || p > list_count) r.status = ST_BAD_POS;
        else begin
          for (int k = p - 1; k + 1 < list_count; k++) list_model[k] = list_model[k + 1];
          list_count--;
        end
      end
    endcase
    r.list_length = 8'(list_count);
    return r;
  endfunction

  function automatic logic [7:0] stray_position(int span);
    case ($urandom_range(0, 4))
      0: return 8'd0;
      1: return 8'(span + 1);
      2: return 8'(LIST_DEPTH);
      3: return 8'(LIST_DEPTH + 1);
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40 && list_count > 0) return list_model[$urandom_range(0, list_count - 1)];
    if (roll < 70) return 32'($signed($urandom_range(0, 7)) - 4);
    return $urandom;
  endfunction

  task automatic send_request(req_kind_t kind, logic [7:0] pos, logic [31:0] val, bit typed,
                              core_res_t typed_res);
    int gap;
    core_res_t pred;
    gap = (sent_count % 200 < 40) ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.req_type <= kind;
    req_bus.position <= pos;
    req_bus.value <= val;
    do @(posedge clk); while (req_bus.ready !== 1'b1);
    pred = list_apply(kind, pos, val);
    result_q.push_back(typed ? typed_res : pred);
    sent_count++;
  endtask

  initial begin
    int roll;
    int bias;
    req_kind_t kind;
    logic [7:0] pos;
    logic [31:0] val;
    core_res_t none;
    none = '{ST_OK, 8'd0, 8'd0};
    dir_rows = '{
      '{REQ_SEARCH, 8'd0,   32'h0000_0000, 1'b1, '{ST_NOT_FOUND, 8'd0, 8'd0}},
      '{REQ_CHANGE, 8'd1,   32'h0000_0000, 1'b1, '{ST_BAD_POS,   8'd0, 8'd0}},
      '{REQ_DELETE, 8'd1,   32'h0000_0000, 1'b1, '{ST_BAD_POS,   8'd0, 8'd0}},
      '{REQ_INSERT, 8'd0,   32'h0000_0005, 1'b1, '{ST_BAD_POS,   8'd0, 8'd0}},
      '{REQ_INSERT, 8'd2,   32'h0000_0005, 1'b1, '{ST_BAD_POS,   8'd0, 8'd0}},
      '{REQ_INSERT, 8'd255, 32'h0000_0005, 1'b1, '{ST_OVERFLOW,  8'd0, 8'd0}},
      '{REQ_INSERT, 8'd65,  32'h0000_0005, 1'b1, '{ST_OVERFLOW,  8'd0, 8'd0}},
      '{REQ_INSERT, 8'd1,   32'h8000_0000, 1'b1, '{ST_OK,        8'd0, 8'd1}},
      '{REQ_INSERT, 8'd2,   32'h7fff_ffff, 1'b1, '{ST_OK,        8'd0, 8'd2}},
      '{REQ_INSERT, 8'd1,   32'hffff_ffff, 1'b1, '{ST_OK,        8'd0, 8'd3}},
      '{REQ_SEARCH, 8'd0,   32'h7fff_ffff, 1'b0, '{ST_OK,        8'd0, 8'd0}},
      '{REQ_SEARCH, 8'd255, 32'h8000_0000, 1'b0, '{ST_OK,        8'd0, 8'd0}},
      '{REQ_INSERT, 8'd2,   32'hffff_ffff, 1'b0, '{ST_OK,        8'd0, 8'd0}},
      '{REQ_SEARCH, 8'd0,   32'hffff_ffff, 1'b0, '{ST_OK,        8'd0, 8'd0}},
      '{REQ_CHANGE, 8'd4,   32'h0000_0000, 1'b0, '{ST_OK,        8'd0, 8'd0}},
      '{REQ_CHANGE, 8'd5,   32'h0000_0001, 1'b1, '{ST_BAD_POS,   8'd0, 8'd4}},
      '{REQ_CHANGE, 8'd65,  32'h0000_0001, 1'b1, '{ST_OVERFLOW,  8'd0, 8'd4}},
      '{REQ_DELETE, 8'd65,  32'h0000_0000, 1'b1, '{ST_OVERFLOW,  8'd0, 8'd4}},
      '{REQ_DELETE, 8'd0,   32'h0000_0000, 1'b1, '{ST_BAD_POS,   8'd0, 8'd4}},
      '{REQ_DELETE, 8'd4,   32'h0000_0000, 1'b0, '{ST_OK,        8'd0, 8'd0}},
      '{REQ_DELETE, 8'd1,   32'h0000_0000, 1'b0, '{ST_OK,        8'd0, 8'd0}},
      '{REQ_SEARCH, 8'd0,   32'h0000_0000, 1'b0, '{ST_OK,        8'd0, 8'd0}},
      '{REQ_INSERT, 8'd3,   32'h55aa_55aa, 1'b0, '{ST_OK,        8'd0, 8'd0}},
      '{REQ_SEARCH, 8'd128, 32'h55aa_55aa, 1'b0, '{ST_OK,        8'd0, 8'd0}}
    };
    req_bus.valid <= 1'b0;
    req_bus.req_type <= REQ_INSERT;
    req_bus.position <= 8'd0;
    req_bus.value <= 32'd0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_request(dir_rows[i].kind, dir_rows[i].pos, dir_rows[i].val, dir_rows[i].typed,
                   dir_rows[i].res);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case ((i / 120) % 4)
        0: bias = 95;
        1: bias = 50;
        2: bias = 10;
        default: bias = 70;
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        kind = req_kind_t'($urandom_range(0, 3));
        pos = 8'($urandom_range(0, 255));
        val = $urandom;
      end else if (roll < 80) begin
        if ($urandom_range(0, 99) < bias) begin
          kind = REQ_INSERT;
          if ($urandom_range(0, 99) < 85) pos = 8'($urandom_range(1, list_count + 1));
          else pos = stray_position(list_count + 1);
        end else begin
          kind = REQ_DELETE;
          if (list_count > 0 && $urandom_range(0, 99) < 85)
            pos = 8'($urandom_range(1, list_count));
          else pos = stray_position(list_count);
        end
        val = pick_value();
      end else if (roll < 90) begin
        kind = REQ_SEARCH;
        pos = 8'($urandom_range(0, 255));
        val = pick_value();
      end else begin
        kind = REQ_CHANGE;
        if (list_count > 0 && $urandom_range(0, 99) < 85)
          pos = 8'($urandom_range(1, list_count));
        else pos = stray_position(list_count);
        val = pick_value();
      end
      send_request(kind, pos, val, 1'b0, none);
    end
    req_bus.valid <= 1'b0;

    while (result_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && result_q.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int hold;
    core_res_t want;
    rsp_bus.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (rsp_seen == HOLD_AT) hold = HOLD_CYCLES;
      else if (rsp_seen % 170 < 35) hold = 0;
      else hold = $urandom_range(0, 15);
      if (hold > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk); while (rsp_bus.valid !== 1'b1);
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d found %0d length %0d",
                   rsp_bus.status, rsp_bus.found_position, rsp_bus.list_length);
      end else begin
        want = result_q.pop_front();
        if (rsp_bus.status !== want.status || rsp_bus.found_position !== want.found_position ||
            rsp_bus.list_length !== want.list_length) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch on result %0d: expected status %0d found %0d length %0d, got %0d %0d %0d",
                     rsp_seen, want.status, want.found_position, want.list_length,
                     rsp_bus.status, rsp_bus.found_position, rsp_bus.list_length);
        end
      end
      rsp_seen++;
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
        idle = 0;
      else
        idle++;
    end
    $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
